// ===== rtl/isq_pkg.sv =====
// Shared types, codes and frame constants of the IR sensor setup sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package isq_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FRAME_IDX_W = $clog2(FRAME_BYTES);

    localparam logic [7:0] SYNC_HEAD = 8'hAA;
    localparam logic [7:0] SYNC_TAIL = 8'h55;
    localparam logic [7:0] FRM_CMD   = 8'h02;
    localparam logic [7:0] ADDR_MODE = 8'h07;
    localparam logic [7:0] ADDR_LVL  = 8'h05;
    localparam logic [7:0] ADDR_OFF  = 8'h03;
    localparam logic [7:0] DATA_UART = 8'h00;
    localparam logic [7:0] DATA_IO   = 8'h02;
    localparam logic [7:0] DATA_OFF  = 8'h00;

    // input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // sensitivity modes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_NEAR = 2'd1;
    localparam logic [1:0] MODE_FAR  = 2'd2;

    // status codes
    localparam logic [1:0] STAT_IDLE = 2'd0;
    localparam logic [1:0] STAT_BUSY = 2'd1;
    localparam logic [1:0] STAT_DONE = 2'd2;
    localparam logic [1:0] STAT_FAIL = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_FIRST   = 3'd1;
    localparam logic [2:0] REG_LATER   = 3'd2;
    localparam logic [2:0] REG_FAR     = 3'd3;
    localparam logic [2:0] REG_NEAR    = 3'd4;

    localparam logic [7:0] RST_TIMEOUT = 8'd70;
    localparam logic [2:0] RST_FIRST   = 3'd3;
    localparam logic [2:0] RST_LATER   = 3'd4;
    localparam logic [7:0] RST_FAR     = 8'h19;
    localparam logic [7:0] RST_NEAR    = 8'h64;

    typedef struct packed {
        logic [7:0] timeout_ticks;
        logic [2:0] first_phase_tries;
        logic [2:0] later_phase_tries;
        logic [7:0] far_level;
        logic [7:0] near_level;
    } isq_cfg_t;

    // one processed request on its way to the output
    typedef struct packed {
        logic       send;
        logic [7:0] addr;
        logic [7:0] data;
        logic [1:0] status;
    } isq_result_t;

    function automatic logic [7:0] frame_byte(input logic [FRAME_IDX_W-1:0] idx,
                                              input logic [7:0] addr,
                                              input logic [7:0] data);
        logic [7:0] b;
        case (idx) inside
            3'd0, 3'd1: b = SYNC_HEAD;
            3'd2:       b = FRM_CMD;
            3'd3:       b = addr;
            3'd4:       b = data;
            3'd5:       b = FRM_CMD + addr + data;
            default:    b = SYNC_TAIL;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/isq_cfg.sv =====
// APB-style configuration registers of the IR sensor setup sequencer.
// Depends on isq_pkg.
`default_nettype none

module isq_cfg
    import isq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output isq_cfg_t         cfg
);

    isq_cfg_t   cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks     <= RST_TIMEOUT;
            cfg_reg.first_phase_tries <= RST_FIRST;
            cfg_reg.later_phase_tries <= RST_LATER;
            cfg_reg.far_level         <= RST_FAR;
            cfg_reg.near_level        <= RST_NEAR;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_TIMEOUT: cfg_reg.timeout_ticks     <= pwdata[7:0];
                REG_FIRST:   cfg_reg.first_phase_tries <= pwdata[2:0];
                REG_LATER:   cfg_reg.later_phase_tries <= pwdata[2:0];
                REG_FAR:     cfg_reg.far_level         <= pwdata[7:0];
                REG_NEAR:    cfg_reg.near_level        <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TIMEOUT: prdata = {24'd0, cfg_reg.timeout_ticks};
            REG_FIRST:   prdata = {29'd0, cfg_reg.first_phase_tries};
            REG_LATER:   prdata = {29'd0, cfg_reg.later_phase_tries};
            REG_FAR:     prdata = {24'd0, cfg_reg.far_level};
            REG_NEAR:    prdata = {24'd0, cfg_reg.near_level};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/isq_core.sv =====
// Input register and sequencing state of the IR sensor setup sequencer.
// Depends on isq_pkg; hands one result per request to isq_tx.
`default_nettype none

module isq_core
    import isq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire isq_cfg_t    cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_cmd,
    input  wire logic [1:0]  in_mode,
    input  wire logic [7:0]  in_rx_byte,
    output logic             res_valid,
    input  wire logic        res_ready,
    output isq_result_t      res
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_UART  = 3'd1,
        PH_SENSE = 3'd2,
        PH_IO    = 3'd3,
        PH_DONE  = 3'd4,
        PH_FAIL  = 3'd5
    } phase_t;

    logic       in_valid_reg;
    logic [1:0] cmd_reg, mode_reg;
    logic [7:0] rxb_reg;

    phase_t     phase_reg, phase_next;
    logic [3:0] rx_pos_reg, rx_pos_next;
    logic [7:0] rx_data_reg, rx_data_next;
    logic [7:0] rx_last_reg, rx_last_next;
    logic [2:0] tries_reg, tries_next;
    logic [7:0] timer_reg, timer_next;
    logic [7:0] sent_reg, sent_next;
    logic [1:0] cmode_reg, cmode_next;

    logic       take;
    logic       do_try;
    logic       busy;
    logic [2:0] limit;
    logic [7:0] addr, data;

    assign take      = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        rx_pos_next  = rx_pos_reg;
        rx_data_next = rx_data_reg;
        rx_last_next = rx_last_reg;
        tries_next   = tries_reg;
        timer_next   = timer_reg;
        sent_next    = sent_reg;
        cmode_next   = cmode_reg;
        do_try       = 1'b0;
        busy         = (phase_reg == PH_UART) || (phase_reg == PH_SENSE) ||
                       (phase_reg == PH_IO);
        limit        = 3'd0;
        addr         = 8'd0;
        data         = 8'd0;
        res.send     = 1'b0;

        case (cmd_reg)
            CMD_START:
            begin
                cmode_next  = (mode_reg == MODE_NEAR || mode_reg == MODE_FAR) ?
                              mode_reg : MODE_OFF;
                phase_next  = PH_UART;
                tries_next  = 3'd0;
                timer_next  = 8'd0;
                rx_pos_next = 4'd0;
                do_try      = 1'b1;
            end
            CMD_BYTE:
            begin
                if (busy)
                begin
                    if (rx_pos_reg == 4'd0)
                    begin
                        if (rxb_reg == SYNC_HEAD)
                            rx_pos_next = 4'd1;
                    end
                    else if (rx_pos_reg < 4'(FRAME_BYTES))
                    begin
                        if (rx_pos_reg == 4'd4)
                            rx_data_next = rxb_reg;
                        if (rx_pos_reg == 4'(FRAME_BYTES - 1))
                        begin
                            rx_last_next = rxb_reg;
                            // echo complete: tail and data byte must match
                            if (rxb_reg == SYNC_TAIL && rx_data_reg == sent_reg)
                            begin
                                tries_next = 3'd0;
                                unique case (phase_reg)
                                    PH_UART: phase_next = PH_SENSE;
                                    PH_SENSE: phase_next = PH_IO;
                                    default: phase_next = PH_DONE;
                                endcase
                            end
                        end
                        rx_pos_next = rx_pos_reg + 4'd1;
                    end
                    else
                        rx_pos_next = 4'd0;
                end
            end
            CMD_TICK:
            begin
                if (timer_reg != 8'd0)
                    timer_next = timer_reg - 8'd1;
                do_try = busy && (timer_next == 8'd0);
            end
            default: ;
        endcase

        if (do_try)
        begin
            limit = (phase_next == PH_UART) ? cfg.first_phase_tries
                                            : cfg.later_phase_tries;
            if (tries_next >= limit)
                phase_next = PH_FAIL;
            else
            begin
                if (phase_next == PH_UART)
                begin
                    addr = ADDR_MODE;
                    data = DATA_UART;
                end
                else if (phase_next == PH_IO)
                begin
                    addr = ADDR_MODE;
                    data = DATA_IO;
                end
                else if (cmode_next == MODE_FAR)
                begin
                    addr = ADDR_LVL;
                    data = cfg.far_level;
                end
                else if (cmode_next == MODE_NEAR)
                begin
                    addr = ADDR_LVL;
                    data = cfg.near_level;
                end
                else
                begin
                    addr = ADDR_OFF;
                    data = DATA_OFF;
                end
                rx_pos_next  = 4'd0;
                rx_data_next = 8'd0;
                rx_last_next = 8'd0;
                tries_next   = tries_next + 3'd1;
                timer_next   = cfg.timeout_ticks;
                sent_next    = data;
                res.send     = 1'b1;
            end
        end

        res.addr = addr;
        res.data = data;
        unique case (phase_next)
            PH_UART, PH_SENSE, PH_IO: res.status = STAT_BUSY;
            PH_DONE:                  res.status = STAT_DONE;
            PH_FAIL:                  res.status = STAT_FAIL;
            default:                  res.status = STAT_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            rx_pos_reg   <= 4'd0;
            rx_data_reg  <= 8'd0;
            rx_last_reg  <= 8'd0;
            tries_reg    <= 3'd0;
            timer_reg    <= 8'd0;
            sent_reg     <= 8'd0;
            cmode_reg    <= 2'd0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (take)
            begin
                phase_reg   <= phase_next;
                rx_pos_reg  <= rx_pos_next;
                rx_data_reg <= rx_data_next;
                rx_last_reg <= rx_last_next;
                tries_reg   <= tries_next;
                timer_reg   <= timer_next;
                sent_reg    <= sent_next;
                cmode_reg   <= cmode_next;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg  <= in_cmd;
            mode_reg <= in_mode;
            rxb_reg  <= in_rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/isq_tx.sv =====
// Result register and frame serializer of the IR sensor setup sequencer.
// Depends on isq_pkg; takes results from isq_core.
`default_nettype none

module isq_tx
    import isq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    output logic             res_ready,
    input  wire isq_result_t res,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic             m_axis_tuser
);

    localparam logic [FRAME_IDX_W-1:0] LAST_IDX = FRAME_IDX_W'(FRAME_BYTES - 1);

    logic                   valid_reg;
    logic [FRAME_IDX_W-1:0] idx_reg;
    isq_result_t            res_reg;
    logic [7:0]             tx_byte;
    logic                   load;

    assign tx_byte       = res_reg.send ? frame_byte(idx_reg, res_reg.addr, res_reg.data)
                                        : 8'd0;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = !res_reg.send || (idx_reg == LAST_IDX);
    assign m_axis_tuser  = res_reg.send;
    assign m_axis_tdata  = {6'd0, res_reg.status, tx_byte};
    assign res_ready     = !valid_reg || (m_axis_tready && m_axis_tlast);
    assign load          = res_ready && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && m_axis_tready)
        begin
            if (m_axis_tlast)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + FRAME_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

`default_nettype wire

// ===== rtl/ir_sensor_config_sequencer_top.sv =====
// Top level of the IR sensor setup sequencer: config port, core, serializer.
// Depends on isq_pkg, isq_cfg, isq_core and isq_tx.
`default_nettype none

// Runs the three-phase setup (uart mode, sensitivity, io mode) of an infrared
// proximity module. Each request (start, received byte or 10 ms tick) is held
// in an input register, processed combinationally and handed to an output
// register. A request that sends a frame yields eight output beats (the frame
// AA AA cmd addr data sum 55 55, tlast on the eighth); any other request yields
// one beat with tuser low and a zero byte. Every beat carries the status after
// the request. One request per cycle is sustained while each gives one beat
// and the output is not stalled; a frame holds the output for its eight beats,
// during which the next request is still taken into the input register. Status
// 3 (failed) and 2 (done) hold until the next start. No clearing pass after reset.
module ir_sensor_config_sequencer_top
    import isq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [1:0] mode, [9:2] rx_byte, rest zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [7:0] tx_byte, [9:8] status, rest zero
    output logic             m_axis_tlast,  // last
    output logic             m_axis_tuser   // [0] tx_valid
);

    isq_cfg_t    cfg;
    isq_result_t res;
    logic        res_valid;
    logic        res_ready;

    isq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isq_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_mode    (s_axis_tdata[1:0]),
        .in_rx_byte (s_axis_tdata[9:2]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    isq_tx u_tx (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== dv/tb_ir_sensor_config_sequencer_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ir_sensor_config_sequencer_top: requests in, frame/status beats out.
// Uses isq_pkg and the RTL only; an in-bench copy of the setup sequencer predicts every beat.
module tb_ir_sensor_config_sequencer_top;
    import isq_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DATA_POS   = 4;
    localparam int TAIL_POS   = FRAME_BYTES - 1;
    localparam int SHORT_SPAN = 8;   // timeouts up to this also get resend and give-up sequences

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_UART, SEQ_SENSE, SEQ_IO, SEQ_DONE, SEQ_FAIL
    } seq_phase_t;

    typedef enum int {ECHO_GOOD, ECHO_BAD_DATA, ECHO_BAD_TAIL, ECHO_SHORT} echo_flaw_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] mode;
        logic [7:0] rx;
    } seq_req_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] status;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [1:0] mode, [9:2] rx_byte, rest zero
    logic [1:0]  s_axis_tuser = '0;    // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [7:0] tx_byte, [9:8] status, rest zero
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // [0] tx_valid

    ir_sensor_config_sequencer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    seq_req_t pending_reqs[$];
    beat_t    expected_beats[$];
    seq_req_t req_on_bus;
    int       reqs_queued = 0;
    int       mismatches = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    bit       steady = 1'b0;

    // sequencer copy used for prediction
    isq_cfg_t   cfg = '{RST_TIMEOUT, RST_FIRST, RST_LATER, RST_FAR, RST_NEAR};
    seq_phase_t seq_phase = SEQ_IDLE;
    logic [3:0] rx_pos = '0;
    logic [7:0] rx_data = '0;
    logic [7:0] rx_tail = '0;
    logic [2:0] tries = '0;
    logic [7:0] wait_left = '0;
    logic [7:0] sent_byte = '0;
    logic [1:0] sel_mode = MODE_OFF;

    function automatic bit in_setup();
        return seq_phase inside {SEQ_UART, SEQ_SENSE, SEQ_IO};
    endfunction

    function automatic logic [1:0] status_now();
        case (seq_phase)
            SEQ_UART, SEQ_SENSE, SEQ_IO: return STAT_BUSY;
            SEQ_DONE:                    return STAT_DONE;
            SEQ_FAIL:                    return STAT_FAIL;
            default:                     return STAT_IDLE;
        endcase
    endfunction

    // {addr, data} of the sensitivity frame
    function automatic logic [15:0] sense_frame(input logic [1:0] m);
        case (m)
            MODE_FAR:  return {ADDR_LVL, cfg.far_level};
            MODE_NEAR: return {ADDR_LVL, cfg.near_level};
            default:   return {ADDR_OFF, DATA_OFF};
        endcase
    endfunction

    function automatic bit send_frame();
        logic [2:0]  limit;
        logic [15:0] ad;
        logic [7:0]  fb [FRAME_BYTES];
        limit = (seq_phase == SEQ_UART) ? cfg.first_phase_tries : cfg.later_phase_tries;
        if (tries >= limit)
        begin
            seq_phase = SEQ_FAIL;
            return 1'b0;
        end
        case (seq_phase)
            SEQ_UART: ad = {ADDR_MODE, DATA_UART};
            SEQ_IO:   ad = {ADDR_MODE, DATA_IO};
            default:  ad = sense_frame(sel_mode);
        endcase
        rx_pos = '0;
        rx_data = '0;
        rx_tail = '0;
        tries = tries + 3'd1;
        wait_left = cfg.timeout_ticks;
        sent_byte = ad[7:0];
        fb = '{SYNC_HEAD, SYNC_HEAD, FRM_CMD, ad[15:8], ad[7:0],
               FRM_CMD + ad[15:8] + ad[7:0], SYNC_TAIL, SYNC_TAIL};
        for (int k = 0; k < FRAME_BYTES; k++)
            expected_beats.push_back(beat_t'{1'b1, fb[k], k == FRAME_BYTES - 1, status_now()});
        return 1'b1;
    endfunction

    function automatic void take_rx_byte(input logic [7:0] b);
        if (!in_setup())
            return;
        if (rx_pos == 0)
        begin
            if (b == SYNC_HEAD)
                rx_pos = 4'd1;
        end
        else if (rx_pos < FRAME_BYTES)
        begin
            if (rx_pos == DATA_POS)
                rx_data = b;
            if (rx_pos == TAIL_POS)
                rx_tail = b;
            rx_pos = rx_pos + 4'd1;
            if (rx_pos == FRAME_BYTES && rx_tail == SYNC_TAIL && rx_data == sent_byte)
            begin
                tries = '0;
                case (seq_phase)
                    SEQ_UART:  seq_phase = SEQ_SENSE;
                    SEQ_SENSE: seq_phase = SEQ_IO;
                    default:   seq_phase = SEQ_DONE;
                endcase
            end
        end
        else
            rx_pos = '0;   // byte after a complete echo is dropped
    endfunction

    function automatic void track_request(input seq_req_t r);
        bit sent;
        sent = 1'b0;
        case (r.cmd)
            CMD_START:
            begin
                sel_mode = (r.mode == MODE_NEAR || r.mode == MODE_FAR) ? r.mode : MODE_OFF;
                seq_phase = SEQ_UART;
                tries = '0;
                wait_left = '0;
                rx_pos = '0;
                sent = send_frame();
            end
            CMD_BYTE:
                take_rx_byte(r.rx);
            CMD_TICK:
            begin
                if (wait_left != 0)
                    wait_left = wait_left - 8'd1;
                if (in_setup() && wait_left == 0)
                    sent = send_frame();
            end
            default: ;
        endcase
        if (!sent)
            expected_beats.push_back(beat_t'{1'b0, 8'h00, 1'b1, status_now()});
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= CMD_START;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                track_request(req_on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!steady && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 12);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, req_on_bus.rx, req_on_bus.mode};
                    s_axis_tuser <= req_on_bus.cmd;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: tdata %h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_axis_tuser !== want.tx_valid)
                    begin
                        $error("tx_valid expected %0d got %0d", want.tx_valid, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[7:0] !== want.tx_byte)
                    begin
                        $error("tx_byte expected %h got %h", want.tx_byte, m_axis_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last expected %0d got %0d", want.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tdata[9:8] !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, m_axis_tdata[9:8]);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_req(input logic [1:0] cmd, input logic [1:0] mode,
                             input logic [7:0] rx);
        pending_reqs.push_back(seq_req_t'{cmd, mode, rx});
        reqs_queued++;
    endtask

    task automatic queue_ticks(input int n);
        for (int k = 0; k < n; k++)
            queue_req(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_echo(input logic [15:0] ad, input echo_flaw_t flaw);
        logic [7:0] fb [FRAME_BYTES];
        int n;
        fb = '{SYNC_HEAD, SYNC_HEAD, FRM_CMD, ad[15:8], ad[7:0],
               FRM_CMD + ad[15:8] + ad[7:0], SYNC_TAIL, SYNC_TAIL};
        n = FRAME_BYTES;
        case (flaw)
            ECHO_BAD_DATA: fb[DATA_POS] = fb[DATA_POS] ^ (8'h01 << $urandom_range(0, 7));
            ECHO_BAD_TAIL: fb[TAIL_POS] = fb[TAIL_POS] ^ (8'h01 << $urandom_range(0, 7));
            ECHO_SHORT:    n = $urandom_range(1, FRAME_BYTES - 1);
            default: ;
        endcase
        for (int k = 0; k < n; k++)
            queue_req(CMD_BYTE, 2'($urandom_range(0, 3)), fb[k]);
    endtask

    task automatic queue_noise(input int n);
        logic [7:0] b;
        for (int k = 0; k < n; k++)
        begin
            b = ($urandom_range(0, 3) == 0) ? SYNC_HEAD : 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0:       queue_req(CMD_START, 2'($urandom_range(0, 3)), b);
                1:       queue_req(CMD_BYTE, 2'($urandom_range(0, 3)), b);
                2:       queue_req(CMD_TICK, 2'($urandom_range(0, 3)), b);
                default: queue_req(CMD_UNUSED, 2'($urandom_range(0, 3)), b);
            endcase
        end
    endtask

    function automatic int tick_span();
        return (cfg.timeout_ticks == 0) ? 1 : int'(cfg.timeout_ticks);
    endfunction

    // one start followed by echoes and ticks for the three phases, mostly well formed
    task automatic queue_session();
        logic [1:0]  m;
        logic [15:0] ad;
        int          pick;
        m = 2'($urandom_range(0, 3));
        queue_req(CMD_START, m, 8'($urandom_range(0, 255)));
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:       ad = {ADDR_MODE, DATA_UART};
                1:       ad = sense_frame(m);
                default: ad = {ADDR_MODE, DATA_IO};
            endcase
            pick = $urandom_range(0, (cfg.timeout_ticks > SHORT_SPAN) ? 4 : 9);
            if (pick >= 5 && pick <= 7)
            begin
                queue_echo(ad, echo_flaw_t'(pick - 4));
                queue_ticks(tick_span());   // wait out the timer, frame goes again
            end
            else if (pick == 8)
            begin
                // no echo at all: resend until the try limit gives up
                queue_ticks(tick_span() * 8);
                queue_noise($urandom_range(1, 2));
                return;
            end
            else if (pick == 9)
                queue_noise($urandom_range(1, 4));
            queue_echo(ad, ECHO_GOOD);
            queue_ticks(tick_span());
        end
        queue_noise($urandom_range(1, 2));
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_beats.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] timeout, input logic [2:0] first,
                                  input logic [2:0] later, input logic [7:0] far,
                                  input logic [7:0] near);
        wait_quiet();
        repeat (4) @(posedge clk);
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_FIRST, {5'b0, first});
        write_reg(REG_LATER, {5'b0, later});
        write_reg(REG_FAR, far);
        write_reg(REG_NEAR, near);
        cfg = '{timeout, first, later, far, near};
        @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: idle requests, odd codes, a bad echo, a dropped ninth byte, restart
        queue_req(CMD_UNUSED, MODE_UNUSED, 8'hFF);
        queue_req(CMD_BYTE, MODE_OFF, SYNC_HEAD);
        queue_req(CMD_TICK, MODE_FAR, 8'h00);
        queue_req(CMD_START, MODE_UNUSED, 8'h00);
        queue_echo({ADDR_MODE, DATA_UART}, ECHO_BAD_DATA);
        queue_req(CMD_BYTE, MODE_OFF, SYNC_HEAD);
        queue_echo({ADDR_MODE, DATA_UART}, ECHO_GOOD);
        queue_req(CMD_START, MODE_FAR, 8'hFF);
        queue_req(CMD_BYTE, MODE_NEAR, 8'h00);

        // corner settings: zero try limits, zero and full-scale timeouts
        apply_settings(8'd0, 3'd0, 3'd0, 8'h00, 8'hFF);
        queue_req(CMD_START, MODE_FAR, 8'h00);
        queue_ticks(2);
        apply_settings(8'd0, 3'd7, 3'd0, 8'hFF, 8'h00);
        queue_session();
        apply_settings(8'd255, 3'd1, 3'd1, 8'h80, 8'h7F);
        queue_req(CMD_START, MODE_NEAR, 8'h5A);
        queue_echo({ADDR_MODE, DATA_UART}, ECHO_GOOD);
        queue_ticks(4);

        // closing stretch with both sides streaming back to back
        apply_settings(8'($urandom_range(1, 4)), 3'($urandom_range(2, 7)),
                       3'($urandom_range(2, 7)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        steady = 1'b1;
        do
            queue_session();
        while (reqs_queued < 90);

        wait_quiet();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("ir_sensor_config_sequencer_top test passed");
        else
            $display("ir_sensor_config_sequencer_top test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ir_sensor_config_sequencer_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/isq_pkg.sv
rtl/isq_cfg.sv
rtl/isq_core.sv
rtl/isq_tx.sv
rtl/ir_sensor_config_sequencer_top.sv
dv/tb_ir_sensor_config_sequencer_top.sv
